FILE: design/sar_format_header_tracker_assert.svh
// assertion helpers shared by the tracker modules
`ifndef SAR_FORMAT_HEADER_TRACKER_ASSERT_SVH
`define SAR_FORMAT_HEADER_TRACKER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SFHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfht assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define SFHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfht assertion failed");

`endif

FILE: design/sfht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfht_pkg;

  localparam int unsigned SUBCOM_SLOTS = 48;
  localparam int unsigned SEQ_SEGMENTS = 21;

  localparam int unsigned SlotW = 6;
  localparam int unsigned SegW  = 6;

  localparam logic [SlotW-1:0] SLOT_LAST  = SlotW'(SUBCOM_SLOTS);
  localparam logic [SlotW-1:0] SLOT_FIRST = SlotW'(1);
  localparam logic [SegW-1:0]  SEG_FULL   = SegW'(SEQ_SEGMENTS);
  localparam logic [SegW-1:0]  SEG_MAX    = '1;

  localparam logic [7:0] ACT_CAL   = 8'hA9;
  localparam logic [7:0] ACT_REP   = 8'hAA;
  localparam logic [7:0] ACT_NOISE = 8'h88;

  typedef struct packed {
    logic [5:0]  subcom_slot;
    logic [7:0]  packet_id;
    logic        zero_format;
    logic [31:0] format_count;
    logic [7:0]  orbit_number;
    logic [31:0] board_time;
    logic [15:0] window_start;
    logic [15:0] pulse_interval;
    logic [7:0]  cal_atten;
    logic [7:0]  rx_atten;
    logic [7:0]  activity;
    logic        first_segment;
  } in_t;

  typedef struct packed {
    logic        is_zero;
    logic        slot_error;
    logic        aux_complete;
    logic        count_continuous;
    logic [31:0] miss_total;
    logic [5:0]  change_mask;
    logic        cal_ready;
    logic        replica_ready;
    logic        echo_ready;
    logic        noise_ready;
    logic        activity_error;
    logic [5:0]  segment_count;
  } out_t;

  typedef struct packed {
    logic slot_error;
    logic aux_complete;
  } aux_res_t;

  typedef struct packed {
    logic        count_continuous;
    logic [31:0] miss_total;
    logic [5:0]  change_mask;
    logic        cal_ready;
    logic        replica_ready;
    logic        echo_ready;
    logic        noise_ready;
    logic        activity_error;
    logic [5:0]  segment_count;
  } fmt_res_t;

endpackage

`default_nettype wire

FILE: design/sfht_aux_track.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sar_format_header_tracker_assert.svh"

module sfht_aux_track (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire sfht_pkg::in_t    data_i,
  output sfht_pkg::aux_res_t    res_o
);

  logic                       valid_q, valid_d;
  logic [7:0]                 packet_q, packet_d;
  logic [sfht_pkg::SlotW-1:0] start_q, start_d;
  logic [sfht_pkg::SlotW-1:0] cur_q, cur_d;
  logic signed [2:0]          rot_q, rot_d;

  logic                       new_pkt;
  logic signed [2:0]          rot_a;
  logic [sfht_pkg::SlotW-1:0] cur_a;
  logic [sfht_pkg::SlotW:0]   cur_inc;
  logic [sfht_pkg::SlotW-1:0] slot;
  logic                       range_bad, step_bad, err, done;

  always_comb begin
    slot     = data_i.subcom_slot;
    new_pkt  = !valid_q || (packet_q != data_i.packet_id);
    rot_a    = new_pkt ? -3'sd1 : rot_q;
    start_d  = new_pkt ? slot : start_q;
    cur_a    = new_pkt ? slot : cur_q;
    cur_inc  = {1'b0, cur_a} + {{sfht_pkg::SlotW{1'b0}}, 1'b1};

    range_bad = (slot > sfht_pkg::SLOT_LAST) || (slot == '0);
    step_bad  = (cur_a != slot) &&
                !((cur_a == sfht_pkg::SLOT_LAST) && (slot == sfht_pkg::SLOT_FIRST)) &&
                (cur_inc != {1'b0, slot});
    err = range_bad || step_bad;

    rot_d = rot_a;
    if (err) begin
      rot_d = 3'sd0;
    end else if ((slot == start_d) && (rot_a < 3'sd3)) begin
      rot_d = rot_a + 3'sd1;
    end
    done = (rot_d == 3'sd1);
    if (done) begin
      rot_d = 3'sd2;
    end

    valid_d  = !err;
    packet_d = data_i.packet_id;
    cur_d    = slot;

    res_o.slot_error   = err;
    res_o.aux_complete = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      packet_q <= '0;
      start_q  <= '0;
      cur_q    <= '0;
      rot_q    <= 3'sd0;
    end else if (fire_i) begin
      valid_q  <= valid_d;
      packet_q <= packet_d;
      start_q  <= start_d;
      cur_q    <= cur_d;
      rot_q    <= rot_d;
    end
  end

  // a completed rotation always parks the count at two
  `SFHT_ASSERT_NEXT(a_done_parks, fire_i && res_o.aux_complete, rot_q == 3'sd2)
  // a slot error always drops the held packet
  `SFHT_ASSERT_NEXT(a_err_drops, fire_i && res_o.slot_error, !valid_q && (rot_q == 3'sd0))

endmodule

`default_nettype wire

FILE: design/sfht_fmt_track.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sar_format_header_tracker_assert.svh"

module sfht_fmt_track (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire sfht_pkg::in_t    data_i,
  output sfht_pkg::fmt_res_t    res_o
);

  logic        pv_q, pv_d;
  logic [31:0] pc_q, pc_d;
  logic [31:0] miss_q, miss_d;
  logic [7:0]  orbit_q, orbit_d;
  logic [31:0] time_q, time_d;
  logic [15:0] win_q, win_d;
  logic [15:0] pri_q, pri_d;
  logic [7:0]  catt_q, catt_d;
  logic [7:0]  ratt_q, ratt_d;
  logic        is_cal_q, is_cal_d;
  logic        ok_q, ok_d;
  logic [sfht_pkg::SegW-1:0] cnt_q, cnt_d;

  logic        cont, is_seg, want_cal;
  logic [5:0]  mask;

  always_comb begin
    pv_d     = pv_q;
    pc_d     = pc_q;
    miss_d   = miss_q;
    orbit_d  = orbit_q;
    time_d   = time_q;
    win_d    = win_q;
    pri_d    = pri_q;
    catt_d   = catt_q;
    ratt_d   = ratt_q;
    is_cal_d = is_cal_q;
    ok_d     = ok_q;
    cnt_d    = cnt_q;
    cont     = 1'b0;
    mask     = '0;
    is_seg   = (data_i.activity == sfht_pkg::ACT_CAL) ||
               (data_i.activity == sfht_pkg::ACT_REP);
    want_cal = (data_i.activity == sfht_pkg::ACT_CAL);

    res_o = '0;

    if (!data_i.zero_format) begin
      cont = !(pv_q && (data_i.format_count != (pc_q + 32'd1)));
      if (!cont) begin
        miss_d = miss_q + (data_i.format_count - pc_q);
      end
      pc_d = data_i.format_count;
      pv_d = 1'b1;

      mask[0] = (orbit_q != data_i.orbit_number);
      mask[1] = (time_q  != data_i.board_time);
      mask[2] = (win_q   != data_i.window_start);
      mask[3] = (pri_q   != data_i.pulse_interval);
      mask[4] = (catt_q  != data_i.cal_atten);
      mask[5] = (ratt_q  != data_i.rx_atten);
      orbit_d = data_i.orbit_number;
      time_d  = data_i.board_time;
      win_d   = data_i.window_start;
      pri_d   = data_i.pulse_interval;
      catt_d  = data_i.cal_atten;
      ratt_d  = data_i.rx_atten;

      if (is_seg) begin
        if (data_i.first_segment) begin
          is_cal_d = want_cal;
          ok_d     = 1'b1;
          cnt_d    = '0;
        end
        ok_d = ok_d && (is_cal_d == want_cal);
        if (ok_d) begin
          ok_d = cont;
          if (cnt_d != sfht_pkg::SEG_MAX) begin
            cnt_d = cnt_d + sfht_pkg::SegW'(1);
          end
        end
        res_o.echo_ready    = 1'b1;
        res_o.cal_ready     = want_cal && is_cal_d && ok_d && (cnt_d == sfht_pkg::SEG_FULL);
        res_o.replica_ready = !want_cal && !is_cal_d && ok_d &&
                              (cnt_d == sfht_pkg::SEG_FULL);
      end else if (data_i.activity == sfht_pkg::ACT_NOISE) begin
        res_o.noise_ready = 1'b1;
      end else begin
        res_o.activity_error = 1'b1;
        ok_d = 1'b0;
      end
    end

    res_o.count_continuous = cont;
    res_o.miss_total       = miss_d;
    res_o.change_mask      = mask;
    res_o.segment_count    = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q     <= 1'b0;
      pc_q     <= '0;
      miss_q   <= '0;
      orbit_q  <= '0;
      time_q   <= '0;
      win_q    <= '0;
      pri_q    <= '0;
      catt_q   <= '0;
      ratt_q   <= '0;
      is_cal_q <= 1'b0;
      ok_q     <= 1'b0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      pv_q     <= pv_d;
      pc_q     <= pc_d;
      miss_q   <= miss_d;
      orbit_q  <= orbit_d;
      time_q   <= time_d;
      win_q    <= win_d;
      pri_q    <= pri_d;
      catt_q   <= catt_d;
      ratt_q   <= ratt_d;
      is_cal_q <= is_cal_d;
      ok_q     <= ok_d;
      cnt_q    <= cnt_d;
    end
  end

  // a non-filler beat always leaves a counter to compare against
  `SFHT_ASSERT_NEXT(a_count_held, fire_i && !data_i.zero_format,
                    pv_q && (pc_q == $past(data_i.format_count)))
  // a ready flag needs a good sequence left behind
  `SFHT_ASSERT_NEXT(a_ready_ok, fire_i && (res_o.cal_ready || res_o.replica_ready),
                    ok_q && (cnt_q == sfht_pkg::SEG_FULL))

endmodule

`default_nettype wire

FILE: design/sar_format_header_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Format header tracker: takes one parsed format header per beat and returns one
// status beat for it, in order. A new header can be taken every clock cycle while
// the input is not stalled; each header is held in the input register and its
// result in the result register, with all tracking state updated in the single
// compare-and-update pass between them. Both channels use valid/stall; the input
// stalls only when both registers are full and the result side is stalling.
// There are no configuration registers, and reset clears all tracking state.

`include "sar_format_header_tracker_assert.svh"

module sar_format_header_tracker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sfht_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sfht_pkg::out_t     out_data_o
);

  logic               s1_valid_q;
  sfht_pkg::in_t      s1_data_q;
  logic               out_valid_q;
  sfht_pkg::out_t     out_data_q, out_data_d;
  logic               adv, fire;
  sfht_pkg::aux_res_t aux_res;
  sfht_pkg::fmt_res_t fmt_res;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;

  sfht_aux_track u_aux (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (s1_data_q),
    .res_o  (aux_res)
  );

  sfht_fmt_track u_fmt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (s1_data_q),
    .res_o  (fmt_res)
  );

  always_comb begin
    out_data_d.is_zero          = s1_data_q.zero_format;
    out_data_d.slot_error       = aux_res.slot_error;
    out_data_d.aux_complete     = aux_res.aux_complete;
    out_data_d.count_continuous = fmt_res.count_continuous;
    out_data_d.miss_total       = fmt_res.miss_total;
    out_data_d.change_mask      = fmt_res.change_mask;
    out_data_d.cal_ready        = fmt_res.cal_ready;
    out_data_d.replica_ready    = fmt_res.replica_ready;
    out_data_d.echo_ready       = fmt_res.echo_ready;
    out_data_d.noise_ready      = fmt_res.noise_ready;
    out_data_d.activity_error   = fmt_res.activity_error;
    out_data_d.segment_count    = fmt_res.segment_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an unblocked header always lands in the result register
  `SFHT_ASSERT_NEXT(a_moves_on, s1_valid_q && !in_stall_o, out_valid_q)
  // the input side only stalls with both stages full
  `SFHT_ASSERT_IMPL(a_stall_full, in_stall_o, s1_valid_q && out_valid_q && out_stall_i)

endmodule

`default_nettype wire
